// ===== rtl/fuc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fuc_pkg
// Shared types, codes and the CRC-16 byte update for the frame unpacker
// with CRC-16 check.
// ----------------------------------------------------------------------------
package fuc_pkg;

    // Parse phase of the current frame.
    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_HEAD = 2'd1,
        PH_PAY  = 2'd2,
        PH_CRC  = 2'd3
    } phase_t;

    // Status codes carried in a status result.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SHORT    = 3'd1;
    localparam logic [2:0] ST_BAD_SYNC = 3'd2;
    localparam logic [2:0] ST_TOO_LONG = 3'd3;
    localparam logic [2:0] ST_BAD_CRC  = 3'd4;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SYNC_PATTERN = 2'd0;
    localparam logic [1:0] CFG_MAX_PAYLOAD  = 2'd1;
    localparam logic [1:0] CFG_CRC_INIT     = 2'd2;

    // Configuration reset values.
    localparam logic [15:0] SYNC_PATTERN_RST = 16'hAA55;
    localparam logic [10:0] MAX_PAYLOAD_RST  = 11'd1024;
    localparam logic [15:0] CRC_INIT_RST     = 16'hFFFF;

    // Hard ceiling on the payload length, applied on top of the register.
    localparam logic [15:0] MAX_PAYLOAD = 16'd1024;

    // Number of header bytes minus one.
    localparam logic [10:0] HEAD_LAST_POS = 11'd5;

    // CRC-16 generator polynomial.
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Configuration register set.
    typedef struct packed {
        logic [15:0] sync_pattern;
        logic [10:0] max_payload_len;
        logic [15:0] crc_init;
    } cfg_t;

    // One result item.
    typedef struct packed {
        logic        kind;
        logic [7:0]  out_byte;
        logic [9:0]  payload_index;
        logic [2:0]  status;
        logic [7:0]  frame_seq;
        logic [7:0]  frame_opcode;
        logic [10:0] frame_length;
        logic [15:0] frame_crc;
    } res_t;

    // CRC-16 update by one byte, MSB first, no reflection.
    function automatic logic [15:0] crc16_step(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (crc[15]) begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

// ===== rtl/fuc_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fuc_parser
// Frame parse state: header capture, header checks, payload pass-through,
// running CRC-16 and the final status decision, one byte per cycle while item_valid is high.
// ----------------------------------------------------------------------------
module fuc_parser (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          item_valid,
    input  logic [7:0]    in_byte,
    input  logic          first_byte,
    input  logic          last_byte,
    input  fuc_pkg::cfg_t cfg,
    output logic          res_valid,
    output fuc_pkg::res_t res
);
    import fuc_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [10:0] pos_reg, pos_next;
    logic [15:0] sync_reg, sync_next;
    logic [7:0]  seq_reg, seq_next;
    logic [7:0]  opcode_reg, opcode_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  wire_hi_reg, wire_hi_next;

    phase_t      phase_v;
    logic [10:0] pos_v;
    logic [10:0] pos_inc;
    logic [15:0] crc_v;
    logic [15:0] crc_upd;
    logic [15:0] limit;
    logic [15:0] len_v;
    logic [15:0] rx_crc_word;
    logic        emit;
    logic [2:0]  emit_status;

    // Effective length limit: the smaller of the register and the ceiling.
    assign limit = ({5'd0, cfg.max_payload_len} > MAX_PAYLOAD) ? MAX_PAYLOAD
                                                               : {5'd0, cfg.max_payload_len};

    // Next state and result for the byte at the head of the pipeline.
    always_comb begin
        phase_v = phase_reg;
        pos_v   = pos_reg;
        crc_v   = crc_reg;
        if (first_byte) begin
            phase_v = PH_HEAD;
            pos_v   = '0;
            crc_v   = cfg.crc_init;
        end

        crc_upd      = crc16_step(crc_v, in_byte);
        pos_inc      = pos_v + 11'd1;
        len_v        = {len_reg[15:8], in_byte};
        rx_crc_word  = {wire_hi_reg, in_byte};

        phase_next   = phase_v;
        pos_next     = pos_v;
        crc_next     = crc_v;
        sync_next    = sync_reg;
        seq_next     = seq_reg;
        opcode_next  = opcode_reg;
        len_next     = len_reg;
        wire_hi_next = wire_hi_reg;
        emit         = 1'b0;
        emit_status  = ST_OK;
        res_valid    = 1'b0;
        res          = '0;

        unique case (phase_v)
            PH_HEAD: begin
                crc_next = crc_upd;
                unique case (pos_v[2:0])
                    3'd0:    sync_next   = {in_byte, 8'h00};
                    3'd1:    sync_next   = {sync_reg[15:8], in_byte};
                    3'd2:    seq_next    = in_byte;
                    3'd3:    opcode_next = in_byte;
                    3'd4:    len_next    = {in_byte, 8'h00};
                    default: len_next    = len_v;
                endcase
                if (pos_v < HEAD_LAST_POS) begin
                    pos_next = pos_inc;
                    if (last_byte) begin
                        emit        = 1'b1;
                        emit_status = ST_SHORT;
                    end
                end else begin
                    // Header checks in order: sync, length, completeness.
                    priority if (sync_reg != cfg.sync_pattern) begin
                        emit        = 1'b1;
                        emit_status = ST_BAD_SYNC;
                    end else if (len_v > limit) begin
                        emit        = 1'b1;
                        emit_status = ST_TOO_LONG;
                    end else if (last_byte) begin
                        emit        = 1'b1;
                        emit_status = ST_SHORT;
                    end else begin
                        pos_next   = '0;
                        phase_next = (len_v == 16'd0) ? PH_CRC : PH_PAY;
                    end
                end
            end
            PH_PAY: begin
                if (last_byte) begin
                    emit        = 1'b1;
                    emit_status = ST_SHORT;
                end else begin
                    crc_next          = crc_upd;
                    res_valid         = 1'b1;
                    res.kind          = KIND_PAYLOAD;
                    res.out_byte      = in_byte;
                    res.payload_index = pos_v[9:0];
                    if ({5'd0, pos_inc} >= len_reg) begin
                        pos_next   = '0;
                        phase_next = PH_CRC;
                    end else begin
                        pos_next = pos_inc;
                    end
                end
            end
            PH_CRC: begin
                if (pos_v == 11'd0) begin
                    wire_hi_next = in_byte;
                    pos_next     = 11'd1;
                    if (last_byte) begin
                        emit        = 1'b1;
                        emit_status = ST_SHORT;
                    end
                end else begin
                    emit        = 1'b1;
                    emit_status = (rx_crc_word == crc_v) ? ST_OK : ST_BAD_CRC;
                end
            end
            default: begin
                // Waiting for a first byte: nothing to do.
            end
        endcase

        // A status result closes the frame.
        if (emit) begin
            phase_next = PH_WAIT;
            res_valid  = 1'b1;
            res        = '0;
            res.kind   = KIND_STATUS;
            res.status = emit_status;
            if (emit_status == ST_OK) begin
                res.frame_seq    = seq_reg;
                res.frame_opcode = opcode_reg;
                res.frame_length = len_reg[10:0];
                res.frame_crc    = rx_crc_word;
            end
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_WAIT;
            pos_reg   <= '0;
        end else if (item_valid) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
        end
    end

    // Header fields and CRC.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= CRC_INIT_RST;
        end else if (item_valid) begin
            crc_reg <= crc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_valid) begin
            sync_reg    <= sync_next;
            seq_reg     <= seq_next;
            opcode_reg  <= opcode_next;
            len_reg     <= len_next;
            wire_hi_reg <= wire_hi_next;
        end
    end

endmodule

// ===== rtl/frame_unpacker_crc16_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_unpacker_crc16_check
// Deframer for sync/length framed packets with a CRC-16 trailer.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one received byte per transaction, with s_tuser
//   marking the first byte of a buffer and s_tlast its last byte. Each frame
//   is a six-byte big-endian header (sync, sequence, opcode, length), the
//   payload and a big-endian CRC-16 word.
//   The m_ channel returns payload bytes (m_tuser low) as they arrive and one
//   status transaction (m_tuser high) per frame. Payload bytes count only if
//   the frame's status is ok.
//   The cfg_ channel writes the sync pattern, the payload length limit and
//   the CRC start value; write it only while the block is idle.
//   Throughput is one byte per cycle unless the receiver stalls. A byte
//   passes an input register, then the parse logic with its one-byte CRC
//   update, then the result register, from which its result goes to m_.
//   When the receiver stalls, the result register holds its transaction and
//   one more byte waits in the input register before s_tready falls.
//   Reset clears both registers and returns the parser to waiting for a
//   first byte with the configuration at its default values.
// ----------------------------------------------------------------------------
module frame_unpacker_crc16_check (
    input  logic        aclk,
    input  logic        aresetn,
    // Input bytes.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tuser,   // [0] first_byte
    input  logic        s_tlast,   // last_byte
    // Results.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [7:0] out_byte, [17:8] payload_index,
                                   // [20:18] status, [28:21] frame_seq,
                                   // [36:29] frame_opcode, [47:37] frame_length,
                                   // [63:48] frame_crc
    output logic        m_tuser,   // [0] kind
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import fuc_pkg::*;

    cfg_t        cfg_reg;
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_first_reg;
    logic        in_last_reg;
    logic        m_valid_reg;
    res_t        m_data_reg;
    logic        out_free;
    logic        advance;
    logic        res_valid;
    res_t        res;

    // Configuration registers, always ready.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_pattern    <= SYNC_PATTERN_RST;
            cfg_reg.max_payload_len <= MAX_PAYLOAD_RST;
            cfg_reg.crc_init        <= CRC_INIT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SYNC_PATTERN: cfg_reg.sync_pattern    <= cfg_data;
                CFG_MAX_PAYLOAD:  cfg_reg.max_payload_len <= cfg_data[10:0];
                CFG_CRC_INIT:     cfg_reg.crc_init        <= cfg_data;
                default: begin
                    // Unused index: the write is dropped.
                end
            endcase
        end
    end

    // Pipeline flow: the input stage moves on whenever the result slot is free.
    assign out_free = !m_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg  <= s_tdata;
            in_first_reg <= s_tuser;
            in_last_reg  <= s_tlast;
        end
    end

    // Parser.
    fuc_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (advance),
        .in_byte    (in_byte_reg),
        .first_byte (in_first_reg),
        .last_byte  (in_last_reg),
        .cfg        (cfg_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= res_valid;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            m_data_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_data_reg.kind;
    assign m_tdata  = {m_data_reg.frame_crc, m_data_reg.frame_length,
                       m_data_reg.frame_opcode, m_data_reg.frame_seq,
                       m_data_reg.status, m_data_reg.payload_index,
                       m_data_reg.out_byte};

    // A payload transaction always carries the ok code.
    a_payload_status_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.kind == KIND_PAYLOAD) |-> m_data_reg.status == ST_OK)
        else $error("payload result with non-ok status");

    // A failed frame reports no header fields.
    a_fail_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.kind == KIND_STATUS && m_data_reg.status != ST_OK)
        |-> (m_data_reg.frame_seq == 8'd0 && m_data_reg.frame_crc == 16'd0
             && m_data_reg.frame_length == 11'd0))
        else $error("header fields set on a failed frame");

    // A stalled result with a byte waiting must hold off the sender.
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && m_valid_reg && !m_tready) |-> !s_tready)
        else $error("input accepted while both stages are full");

    // Status codes stay within the defined set.
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && res_valid) |-> (res.status == ST_OK || res.status == ST_SHORT
            || res.status == ST_BAD_SYNC || res.status == ST_TOO_LONG
            || res.status == ST_BAD_CRC))
        else $error("undefined status code");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking testbench for the frame unpacker with CRC-16 check.
// ----------------------------------------------------------------------------
// A behavioral deframer in this file predicts every payload and status
// transaction from the bytes that the block accepts. A directed opening
// covers stray bytes, restarts, short buffers, header checks and an empty
// payload. Random frames follow, nearly half of them well formed with random
// content, the rest noise, corrupted, cut short or restarted. They run under
// several register settings, the extremes among them, and headers at the
// length ceiling close the run. Both sides of the stream idle at random.
// ----------------------------------------------------------------------------
module testbench;

    import fuc_pkg::*;

    // Run limits and timing.
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_PAD   = 6;
    localparam int PHASE_ITEMS = 200;
    localparam int LOG_LIMIT   = 40;

    // Kinds of random frame.
    localparam int FR_NOISE    = 0;
    localparam int FR_GOOD     = 1;
    localparam int FR_BAD_CRC  = 2;
    localparam int FR_BAD_SYNC = 3;
    localparam int FR_TOO_LONG = 4;
    localparam int FR_SHORT    = 5;
    localparam int FR_RESTART  = 6;

    // One byte waiting for the link driver, with its idle cycles up front.
    typedef struct {
        logic [7:0] data;
        logic       first;
        logic       last;
        int         gap;
    } link_byte_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic        s_tuser   = 1'b0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_SYNC_PATTERN;
    logic [15:0] cfg_data  = 16'h0000;

    link_byte_t  link_bytes[$];
    logic [7:0]  frame_bytes[$];
    res_t        awaited_results[$];

    int          errors      = 0;
    int          cycle_count = 0;
    int          sent_items  = 0;
    int          stall_left  = 0;
    logic        in_taken    = 1'b0;
    logic        tx_calm     = 1'b0;
    logic        rx_calm     = 1'b0;

    // Register values that the stimulus builds its frames for.
    logic [15:0] gen_sync     = SYNC_PATTERN_RST;
    logic [10:0] gen_max      = MAX_PAYLOAD_RST;
    logic [15:0] gen_crc_init = CRC_INIT_RST;

    // Predicted deframer state and its copy of the registers.
    phase_t      dfr_phase;
    logic [10:0] dfr_pos;
    logic [15:0] dfr_sync_word;
    logic [7:0]  dfr_seq;
    logic [7:0]  dfr_opcode;
    logic [15:0] dfr_length;
    logic [15:0] dfr_crc;
    logic [7:0]  dfr_crc_high;
    logic [15:0] reg_sync;
    logic [10:0] reg_max_len;
    logic [15:0] reg_crc_init;

    frame_unpacker_crc16_check u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock and the single reset pulse.
    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Reporting
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= LOG_LIMIT) begin
            $display("ERROR at %0t: %s", $time, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
        end
    endtask

    // ------------------------------------------------------------------------
    // Deframer prediction
    // ------------------------------------------------------------------------

    // CRC-16 with polynomial 0x1021, one input bit at a time, MSB first.
    function automatic logic [15:0] crc_ccitt_byte(input logic [15:0] c,
                                                   input logic [7:0]  d);
        logic [15:0] r;
        logic        fb;
        r = c;
        for (int k = 7; k >= 0; k--) begin
            fb = r[15] ^ d[k];
            r  = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return r;
    endfunction

    task automatic reset_deframer();
        reg_sync      = SYNC_PATTERN_RST;
        reg_max_len   = MAX_PAYLOAD_RST;
        reg_crc_init  = CRC_INIT_RST;
        dfr_phase     = PH_WAIT;
        dfr_pos       = '0;
        dfr_sync_word = '0;
        dfr_seq       = '0;
        dfr_opcode    = '0;
        dfr_length    = '0;
        dfr_crc       = CRC_INIT_RST;
        dfr_crc_high  = '0;
    endtask

    task automatic apply_reg(input logic [1:0] idx, input logic [15:0] val);
        case (idx)
            CFG_SYNC_PATTERN: reg_sync     = val;
            CFG_MAX_PAYLOAD:  reg_max_len  = val[10:0];
            CFG_CRC_INIT:     reg_crc_init = val;
            default: ;
        endcase
    endtask

    // A status closes the frame; header fields ride along only when ok.
    task automatic end_frame(input logic [2:0] st, input logic [15:0] crc_word);
        res_t r;
        r        = '0;
        r.kind   = KIND_STATUS;
        r.status = st;
        if (st == ST_OK) begin
            r.frame_seq    = dfr_seq;
            r.frame_opcode = dfr_opcode;
            r.frame_length = dfr_length[10:0];
            r.frame_crc    = crc_word;
        end
        awaited_results.push_back(r);
        dfr_phase = PH_WAIT;
    endtask

    task automatic deframe_byte(input logic [7:0] b, input logic first, input logic last);
        res_t        r;
        logic [15:0] limit;
        logic [15:0] crc_word;
        if (first) begin
            dfr_phase = PH_HEAD;
            dfr_pos   = '0;
            dfr_crc   = reg_crc_init;
        end
        case (dfr_phase)
            PH_HEAD: begin
                dfr_crc = crc_ccitt_byte(dfr_crc, b);
                case (dfr_pos)
                    11'd0:   dfr_sync_word = {b, 8'h00};
                    11'd1:   dfr_sync_word = {dfr_sync_word[15:8], b};
                    11'd2:   dfr_seq = b;
                    11'd3:   dfr_opcode = b;
                    11'd4:   dfr_length = {b, 8'h00};
                    default: dfr_length = {dfr_length[15:8], b};
                endcase
                if (dfr_pos < HEAD_LAST_POS) begin
                    dfr_pos++;
                    if (last) begin
                        end_frame(ST_SHORT, 16'h0000);
                    end
                end else begin
                    // Header checks: sync, then length, then completeness.
                    limit = ({5'd0, reg_max_len} > MAX_PAYLOAD) ? MAX_PAYLOAD
                                                                : {5'd0, reg_max_len};
                    if (dfr_sync_word != reg_sync) begin
                        end_frame(ST_BAD_SYNC, 16'h0000);
                    end else if (dfr_length > limit) begin
                        end_frame(ST_TOO_LONG, 16'h0000);
                    end else if (last) begin
                        end_frame(ST_SHORT, 16'h0000);
                    end else begin
                        dfr_pos = '0;
                        if (dfr_length == 16'd0) begin
                            dfr_phase = PH_CRC;
                        end else begin
                            dfr_phase = PH_PAY;
                        end
                    end
                end
            end
            PH_PAY: begin
                if (last) begin
                    end_frame(ST_SHORT, 16'h0000);
                end else begin
                    dfr_crc         = crc_ccitt_byte(dfr_crc, b);
                    r               = '0;
                    r.kind          = KIND_PAYLOAD;
                    r.out_byte      = b;
                    r.payload_index = dfr_pos[9:0];
                    awaited_results.push_back(r);
                    dfr_pos = dfr_pos + 11'd1;
                    if ({5'd0, dfr_pos} >= dfr_length) begin
                        dfr_pos   = '0;
                        dfr_phase = PH_CRC;
                    end
                end
            end
            PH_CRC: begin
                if (dfr_pos == 11'd0) begin
                    dfr_crc_high = b;
                    dfr_pos      = 11'd1;
                    if (last) begin
                        end_frame(ST_SHORT, 16'h0000);
                    end
                end else begin
                    crc_word = {dfr_crc_high, b};
                    end_frame((crc_word == dfr_crc) ? ST_OK : ST_BAD_CRC, crc_word);
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_result();
        res_t want;
        if (awaited_results.size() == 0) begin
            report_mismatch($sformatf("result with none expected, tuser %b tdata %h",
                                      m_tuser, m_tdata));
        end else begin
            want = awaited_results.pop_front();
            check_field("kind", {15'd0, m_tuser}, {15'd0, want.kind});
            check_field("out_byte", {8'd0, m_tdata[7:0]}, {8'd0, want.out_byte});
            check_field("payload_index", {6'd0, m_tdata[17:8]}, {6'd0, want.payload_index});
            check_field("status", {13'd0, m_tdata[20:18]}, {13'd0, want.status});
            check_field("frame_seq", {8'd0, m_tdata[28:21]}, {8'd0, want.frame_seq});
            check_field("frame_opcode", {8'd0, m_tdata[36:29]}, {8'd0, want.frame_opcode});
            check_field("frame_length", {5'd0, m_tdata[47:37]}, {5'd0, want.frame_length});
            check_field("frame_crc", m_tdata[63:48], want.frame_crc);
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor: samples every handshake at the rising edge.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            in_taken = 1'b0;
            reset_deframer();
        end else begin
            if (m_tvalid && m_tready) begin
                check_result();
            end
            in_taken = s_tvalid && s_tready;
            if (in_taken) begin
                deframe_byte(s_tdata, s_tuser, s_tlast);
            end
            if (cfg_valid && cfg_ready) begin
                apply_reg(cfg_index, cfg_data);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Idle patterns: mostly none or short, now and then long.
    // ------------------------------------------------------------------------
    function automatic int next_gap(input logic calm);
        int pick;
        pick = $urandom_range(0, 99);
        if (calm || pick < 60) begin
            return 0;
        end else if (pick < 90) begin
            return $urandom_range(1, 3);
        end else if (pick < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // Link driver: presents queued bytes at the falling edge.
    always @(negedge aclk) begin
        link_byte_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !in_taken) begin
            // Hold the transaction until it is taken.
        end else if (link_bytes.size() != 0 && link_bytes[0].gap != 0) begin
            link_bytes[0].gap = link_bytes[0].gap - 1;
            s_tvalid <= 1'b0;
        end else if (link_bytes.size() != 0) begin
            nxt = link_bytes.pop_front();
            s_tvalid <= 1'b1;
            s_tdata  <= nxt.data;
            s_tuser  <= nxt.first;
            s_tlast  <= nxt.last;
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Result receiver: random stalls on m_tready.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else begin
            stall_left = next_gap(rx_calm);
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    function automatic logic [7:0] rand_octet();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int gen_limit();
        return (gen_max > 11'd1024) ? 1024 : int'(gen_max);
    endfunction

    task automatic push_item(input logic [7:0] data, input logic first, input logic last,
                             input logic counted);
        link_byte_t it;
        it.data  = data;
        it.first = first;
        it.last  = last;
        it.gap   = next_gap(tx_calm);
        link_bytes.push_back(it);
        if (counted) begin
            sent_items++;
        end
    endtask

    // Header, payload and CRC trailer for the current register values.
    task automatic build_frame(input logic [15:0] sw, input logic [7:0] seq,
                               input logic [7:0] opc, input logic [15:0] hl,
                               input int plen, input logic [15:0] crc_flip);
        logic [15:0] c;
        frame_bytes.delete();
        frame_bytes.push_back(sw[15:8]);
        frame_bytes.push_back(sw[7:0]);
        frame_bytes.push_back(seq);
        frame_bytes.push_back(opc);
        frame_bytes.push_back(hl[15:8]);
        frame_bytes.push_back(hl[7:0]);
        repeat (plen) frame_bytes.push_back(rand_octet());
        c = gen_crc_init;
        foreach (frame_bytes[i]) c = crc_ccitt_byte(c, frame_bytes[i]);
        c = c ^ crc_flip;
        frame_bytes.push_back(c[15:8]);
        frame_bytes.push_back(c[7:0]);
    endtask

    // Sends the first n bytes of the frame, optionally marking the last one.
    task automatic send_run(input int n, input logic with_last);
        for (int i = 0; i < n; i++) begin
            push_item(frame_bytes[i], i == 0, with_last && (i == n - 1), 1'b1);
        end
    endtask

    // Bytes after a decision, ignored up to the next first marker.
    task automatic maybe_trailer();
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3)) push_item(rand_octet(), 1'b0,
                                                    1'($urandom_range(0, 1)), 1'b0);
        end
    endtask

    task automatic queue_random_frame();
        int          pick;
        int          kind;
        int          lim;
        int          plen;
        int          cap;
        logic [15:0] hl;
        lim     = gen_limit();
        tx_calm = ($urandom_range(0, 99) < 15);
        rx_calm = ($urandom_range(0, 99) < 15);
        pick    = $urandom_range(0, 99);
        if (pick < 5) begin
            kind = FR_NOISE;
        end else if (pick < 50) begin
            kind = FR_GOOD;
        end else if (pick < 62) begin
            kind = FR_BAD_CRC;
        end else if (pick < 70) begin
            kind = FR_BAD_SYNC;
        end else if (pick < 78) begin
            kind = FR_TOO_LONG;
        end else if (pick < 93) begin
            kind = FR_SHORT;
        end else begin
            kind = FR_RESTART;
        end
        cap  = ($urandom_range(0, 99) < 85) ? 12 : 80;
        plen = $urandom_range(0, (lim < cap) ? lim : cap);
        hl   = 16'(plen);
        case (kind)
            FR_NOISE: begin
                repeat ($urandom_range(1, 4)) push_item(rand_octet(), 1'b0,
                                                        1'($urandom_range(0, 1)), 1'b0);
            end
            FR_GOOD, FR_BAD_CRC: begin
                build_frame(gen_sync, rand_octet(), rand_octet(), hl, plen,
                            (kind == FR_BAD_CRC) ? 16'($urandom_range(1, 65535)) : 16'h0000);
                send_run(frame_bytes.size(), 1'($urandom_range(0, 1)));
                maybe_trailer();
            end
            FR_BAD_SYNC: begin
                build_frame(gen_sync ^ 16'($urandom_range(1, 65535)), rand_octet(),
                            rand_octet(), hl, 0, 16'h0000);
                send_run(6, 1'($urandom_range(0, 1)));
                maybe_trailer();
            end
            FR_TOO_LONG: begin
                pick = $urandom_range(0, 3);
                if (pick < 2) begin
                    hl = 16'(lim + 1 + $urandom_range(0, 20));
                end else if (pick == 2) begin
                    hl = 16'hFFFF;
                end else begin
                    hl = 16'($urandom_range(lim + 1, 65535));
                end
                build_frame(gen_sync, rand_octet(), rand_octet(), hl, 0, 16'h0000);
                send_run(6, 1'($urandom_range(0, 1)));
                maybe_trailer();
            end
            default: begin
                // Cut anywhere before the final CRC byte, with or without last.
                build_frame(gen_sync, rand_octet(), rand_octet(), hl, plen, 16'h0000);
                send_run($urandom_range(1, frame_bytes.size() - 1), kind == FR_SHORT);
            end
        endcase
    endtask

    task automatic random_phase(input int n);
        int target;
        target = sent_items + n;
        while (sent_items < target) begin
            queue_random_frame();
        end
    endtask

    // Holds the sender until the block has delivered everything predicted.
    task automatic wait_idle();
        while (link_bytes.size() != 0 || s_tvalid || awaited_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_PAD) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SYNC_PATTERN: gen_sync     = val;
            CFG_MAX_PAYLOAD:  gen_max      = val[10:0];
            CFG_CRC_INIT:     gen_crc_init = val;
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [15:0] sw, input logic [15:0] max_len,
                            input logic [15:0] init);
        wait_idle();
        write_reg(CFG_SYNC_PATTERN, sw);
        write_reg(CFG_MAX_PAYLOAD, max_len);
        write_reg(CFG_CRC_INIT, init);
    endtask

    initial begin
        @(posedge aresetn);

        // Directed opening under the reset register values.
        // A stray byte before any first marker is dropped.
        push_item(8'h5A, 1'b0, 1'b1, 1'b1);
        // A header restarted by a new first marker ends without a status.
        build_frame(16'h00FF, 8'h00, 8'h00, 16'h0000, 0, 16'h0000);
        send_run(2, 1'b0);
        // Last marker inside the header reports short even with a wrong sync.
        build_frame(16'h1234, 8'h56, 8'h00, 16'h0000, 0, 16'h0000);
        send_run(3, 1'b1);
        // A wrong sync wins over the last marker on the sixth byte.
        build_frame(16'h0000, 8'h00, 8'hFF, 16'h0000, 0, 16'h0000);
        send_run(6, 1'b1);
        // Bytes after a decision are ignored.
        push_item(8'hA5, 1'b0, 1'b0, 1'b1);
        // Empty payload frame with extreme header bytes.
        build_frame(gen_sync, 8'hFF, 8'h00, 16'h0000, 0, 16'h0000);
        send_run(frame_bytes.size(), 1'b1);
        // Largest length word in the header.
        build_frame(gen_sync, 8'h00, 8'hFF, 16'hFFFF, 0, 16'h0000);
        send_run(6, 1'b0);

        // Random frames under several register settings.
        random_phase(PHASE_ITEMS);
        set_regs(16'h0000, 16'd0, 16'h0000);
        random_phase(PHASE_ITEMS);
        set_regs(16'hFFFF, 16'd16, 16'h1D0F);
        random_phase(PHASE_ITEMS);
        set_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(1, 64)),
                 16'($urandom_range(0, 65535)));
        random_phase(PHASE_ITEMS);
        set_regs(16'h7E81, 16'd1024, 16'hFFFF);
        random_phase(PHASE_ITEMS);

        // Register above the hard ceiling: a header at the full length passes
        // the checks and its payload starts, while one byte more is too large.
        set_regs(16'hAA55, 16'd2047, 16'h0000);
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        build_frame(gen_sync, rand_octet(), rand_octet(), 16'd1024, 4, 16'h0000);
        send_run(frame_bytes.size() - 2, 1'b1);
        build_frame(gen_sync, rand_octet(), rand_octet(), 16'd1025, 0, 16'h0000);
        send_run(6, 1'b0);

        wait_idle();
        if (errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
